/* hdl/tpsg_pkg.sv */
`default_nettype none

package tpsg_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);

    localparam int COORD_W    = 24;
    localparam int HEAD_W     = 9;
    localparam int STEP_W     = 16;
    localparam int TRIG_W     = 15;
    localparam int LEVEL_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int SYM_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int OUT_DATA_W = 104;

    localparam logic [SYM_W-1:0] SYM_FWD   = 8'd70;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'd43;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'd45;
    localparam logic [SYM_W-1:0] SYM_PUSH  = 8'd91;
    localparam logic [SYM_W-1:0] SYM_POP   = 8'd93;

    localparam logic [STATUS_W-1:0] STATUS_NONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SEGMENT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_DEGREES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 3'd4;

    localparam logic [STEP_W-1:0]  RST_STEP_LENGTH   = 16'd3072;
    localparam logic [HEAD_W-1:0]  RST_TURN_DEGREES  = 9'd15;
    localparam logic [COORD_W-1:0] RST_START_X       = 24'd102400;
    localparam logic [COORD_W-1:0] RST_START_Y       = 24'd204800;
    localparam logic [HEAD_W-1:0]  RST_START_HEADING = 9'd90;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [HEAD_W-1:0] heading_t;

    typedef struct packed {
        coord_t   x;
        coord_t   y;
        heading_t h;
    } pose_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stack_ctrl_t;

    function automatic heading_t wrap_deg(input logic [HEAD_W:0] v);
        if (v >= 10'd360)
            return HEAD_W'(v - 10'd360);
        else
            return HEAD_W'(v);
    endfunction

    function automatic coord_t sat_coord(input logic signed [COORD_W:0] v);
        if (v[COORD_W] != v[COORD_W-1])
            return v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        else
            return v[COORD_W-1:0];
    endfunction

    function automatic logic [TRIG_W-1:0] quarter_sine(input logic [6:0] idx);
        logic [TRIG_W-1:0] s;
        case (idx)
            7'd0:  s = 15'd0;     7'd1:  s = 15'd572;   7'd2:  s = 15'd1144;
            7'd3:  s = 15'd1715;  7'd4:  s = 15'd2286;  7'd5:  s = 15'd2856;
            7'd6:  s = 15'd3425;  7'd7:  s = 15'd3993;  7'd8:  s = 15'd4560;
            7'd9:  s = 15'd5126;  7'd10: s = 15'd5690;  7'd11: s = 15'd6252;
            7'd12: s = 15'd6813;  7'd13: s = 15'd7371;  7'd14: s = 15'd7927;
            7'd15: s = 15'd8481;  7'd16: s = 15'd9032;  7'd17: s = 15'd9580;
            7'd18: s = 15'd10126; 7'd19: s = 15'd10668; 7'd20: s = 15'd11207;
            7'd21: s = 15'd11743; 7'd22: s = 15'd12275; 7'd23: s = 15'd12803;
            7'd24: s = 15'd13328; 7'd25: s = 15'd13848; 7'd26: s = 15'd14365;
            7'd27: s = 15'd14876; 7'd28: s = 15'd15384; 7'd29: s = 15'd15886;
            7'd30: s = 15'd16384; 7'd31: s = 15'd16877; 7'd32: s = 15'd17364;
            7'd33: s = 15'd17847; 7'd34: s = 15'd18324; 7'd35: s = 15'd18795;
            7'd36: s = 15'd19261; 7'd37: s = 15'd19720; 7'd38: s = 15'd20174;
            7'd39: s = 15'd20622; 7'd40: s = 15'd21063; 7'd41: s = 15'd21498;
            7'd42: s = 15'd21926; 7'd43: s = 15'd22348; 7'd44: s = 15'd22763;
            7'd45: s = 15'd23170; 7'd46: s = 15'd23571; 7'd47: s = 15'd23965;
            7'd48: s = 15'd24351; 7'd49: s = 15'd24730; 7'd50: s = 15'd25102;
            7'd51: s = 15'd25466; 7'd52: s = 15'd25822; 7'd53: s = 15'd26170;
            7'd54: s = 15'd26510; 7'd55: s = 15'd26842; 7'd56: s = 15'd27166;
            7'd57: s = 15'd27482; 7'd58: s = 15'd27789; 7'd59: s = 15'd28088;
            7'd60: s = 15'd28378; 7'd61: s = 15'd28660; 7'd62: s = 15'd28932;
            7'd63: s = 15'd29197; 7'd64: s = 15'd29452; 7'd65: s = 15'd29698;
            7'd66: s = 15'd29935; 7'd67: s = 15'd30163; 7'd68: s = 15'd30382;
            7'd69: s = 15'd30592; 7'd70: s = 15'd30792; 7'd71: s = 15'd30983;
            7'd72: s = 15'd31164; 7'd73: s = 15'd31336; 7'd74: s = 15'd31499;
            7'd75: s = 15'd31651; 7'd76: s = 15'd31795; 7'd77: s = 15'd31928;
            7'd78: s = 15'd32052; 7'd79: s = 15'd32166; 7'd80: s = 15'd32270;
            7'd81: s = 15'd32365; 7'd82: s = 15'd32449; 7'd83: s = 15'd32524;
            7'd84: s = 15'd32588; 7'd85: s = 15'd32643; 7'd86: s = 15'd32688;
            7'd87: s = 15'd32723; 7'd88: s = 15'd32748; 7'd89: s = 15'd32763;
            7'd90: s = 15'd32767;
            default: s = 15'd0;
        endcase
        return s;
    endfunction

    // sign in the top bit, magnitude below
    function automatic logic [TRIG_W:0] sine_mag(input heading_t h);
        logic [6:0] idx;
        logic       neg;
        neg = (h > 9'd180);
        if (h <= 9'd90)
            idx = h[6:0];
        else if (h <= 9'd180)
            idx = 7'(9'd180 - h);
        else if (h <= 9'd270)
            idx = 7'(h - 9'd180);
        else
            idx = 7'(9'd360 - h);
        return {neg, quarter_sine(idx)};
    endfunction

endpackage

`default_nettype wire

/* hdl/tpsg_seg_calc.sv */
`default_nettype none

module tpsg_seg_calc
(
    input  wire logic [tpsg_pkg::STEP_W-1:0] step,
    input  wire tpsg_pkg::heading_t          heading,
    input  wire tpsg_pkg::coord_t            pos_x,
    input  wire tpsg_pkg::coord_t            pos_y,
    output tpsg_pkg::coord_t                 x_end,
    output tpsg_pkg::coord_t                 y_end
);

    logic [tpsg_pkg::HEAD_W:0]           cos_arg;
    tpsg_pkg::heading_t                  cos_h;
    logic [tpsg_pkg::TRIG_W:0]           cos_sm;
    logic [tpsg_pkg::TRIG_W:0]           sin_sm;
    logic [30:0]                         cos_prod;
    logic [30:0]                         sin_prod;
    logic [31:0]                         cos_rnd;
    logic [31:0]                         sin_rnd;
    logic signed [tpsg_pkg::COORD_W:0]   dx;
    logic signed [tpsg_pkg::COORD_W:0]   dy;
    logic signed [tpsg_pkg::COORD_W:0]   sum_x;
    logic signed [tpsg_pkg::COORD_W:0]   sum_y;

    always_comb
    begin
        cos_arg  = {1'b0, heading} + 10'd90;
        cos_h    = tpsg_pkg::wrap_deg(cos_arg);
        cos_sm   = tpsg_pkg::sine_mag(cos_h);
        sin_sm   = tpsg_pkg::sine_mag(heading);
        cos_prod = {15'b0, step} * {16'b0, cos_sm[tpsg_pkg::TRIG_W-1:0]};
        sin_prod = {15'b0, step} * {16'b0, sin_sm[tpsg_pkg::TRIG_W-1:0]};
        cos_rnd  = {1'b0, cos_prod} + 32'd16384;
        sin_rnd  = {1'b0, sin_prod} + 32'd16384;
        dx = cos_sm[tpsg_pkg::TRIG_W] ? -$signed({8'b0, cos_rnd[31:15]})
                                      :  $signed({8'b0, cos_rnd[31:15]});
        dy = sin_sm[tpsg_pkg::TRIG_W] ? -$signed({8'b0, sin_rnd[31:15]})
                                      :  $signed({8'b0, sin_rnd[31:15]});
        sum_x = {pos_x[tpsg_pkg::COORD_W-1], pos_x} + dx;
        sum_y = {pos_y[tpsg_pkg::COORD_W-1], pos_y} - dy;
        x_end = tpsg_pkg::sat_coord(sum_x);
        y_end = tpsg_pkg::sat_coord(sum_y);
    end

endmodule

`default_nettype wire

/* hdl/tpsg_pose_stack.sv */
`default_nettype none

module tpsg_pose_stack
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tpsg_pkg::stack_ctrl_t         ctrl,
    input  wire tpsg_pkg::pose_t               pose_in,
    output tpsg_pkg::pose_t                    top,
    output logic [tpsg_pkg::STACK_CW-1:0]      count,
    output logic [tpsg_pkg::STACK_CW-1:0]      count_next
);

    tpsg_pkg::pose_t                  mem [tpsg_pkg::STACK_DEPTH];
    tpsg_pkg::pose_t                  top_reg;
    tpsg_pkg::pose_t                  top_next;
    tpsg_pkg::pose_t                  rd_reg;
    logic [tpsg_pkg::STACK_CW-1:0]    count_reg;
    logic [tpsg_pkg::STACK_CW-1:0]    wptr;
    logic [tpsg_pkg::STACK_CW-1:0]    rptr;
    logic [tpsg_pkg::STACK_AW-1:0]    waddr;
    logic [tpsg_pkg::STACK_AW-1:0]    raddr;
    logic                             we;

    // top of stack sits in top_reg; memory holds the entries below it,
    // and rd_reg always carries the entry just under the top
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        we         = 1'b0;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
            top_next   = pose_in;
            we         = (count_reg != '0);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
            top_next   = rd_reg;
        end
        wptr  = count_reg - 1'b1;
        rptr  = count_next - 2'd2;
        waddr = wptr[tpsg_pkg::STACK_AW-1:0];
        raddr = rptr[tpsg_pkg::STACK_AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= top_reg;
        if (we && (waddr == raddr))
            rd_reg <= top_reg;
        else
            rd_reg <= mem[raddr];
        top_reg <= top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign top   = top_reg;
    assign count = count_reg;

endmodule

`default_nettype wire

/* hdl/turtle_path_segment_generator_unit.sv */
// Path: an accepted input beat goes into the input registers, its result into the m_ registers.
// Throughput: one beat per cycle while m_tready keeps the output free; the pose loop closes
//   through one table lookup, multiply, add and saturate combinationally.
// Reset: registers take their defaults, pose loads the default start pose,
//   branch stack is empty; stack memory contents are not cleared.
`default_nettype none

module turtle_path_segment_generator_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [tpsg_pkg::SYM_W-1:0]          s_tdata,  // symbol
    input  wire logic [0:0]                          s_tuser,  // restart
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // x_start, y_start, x_end, y_end, stack_level, zero pad
    output logic [tpsg_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic [tpsg_pkg::STATUS_W-1:0]            m_tuser,  // status
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tpsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tpsg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [tpsg_pkg::STEP_W-1:0]     step_length_reg;
    logic [tpsg_pkg::HEAD_W-1:0]     turn_degrees_reg;
    logic [tpsg_pkg::COORD_W-1:0]    start_x_reg;
    logic [tpsg_pkg::COORD_W-1:0]    start_y_reg;
    logic [tpsg_pkg::HEAD_W-1:0]     start_heading_reg;

    logic                            in_valid_reg;
    logic [tpsg_pkg::SYM_W-1:0]      in_sym_reg;
    logic                            in_restart_reg;

    tpsg_pkg::coord_t                pos_x_reg;
    tpsg_pkg::coord_t                pos_x_next;
    tpsg_pkg::coord_t                pos_y_reg;
    tpsg_pkg::coord_t                pos_y_next;
    tpsg_pkg::heading_t              heading_reg;
    tpsg_pkg::heading_t              heading_next;

    logic                            out_valid_reg;
    logic [tpsg_pkg::STATUS_W-1:0]   status_reg;
    logic [tpsg_pkg::STATUS_W-1:0]   status_next;
    tpsg_pkg::coord_t                xs_reg;
    tpsg_pkg::coord_t                xs_next;
    tpsg_pkg::coord_t                ys_reg;
    tpsg_pkg::coord_t                ys_next;
    tpsg_pkg::coord_t                xe_reg;
    tpsg_pkg::coord_t                xe_next;
    tpsg_pkg::coord_t                ye_reg;
    tpsg_pkg::coord_t                ye_next;
    logic [tpsg_pkg::LEVEL_W-1:0]    level_reg;

    logic                            out_free;
    logic                            fire;
    tpsg_pkg::heading_t              turn;
    tpsg_pkg::coord_t                seg_x_end;
    tpsg_pkg::coord_t                seg_y_end;
    tpsg_pkg::stack_ctrl_t           stk_ctrl;
    tpsg_pkg::pose_t                 cur_pose;
    tpsg_pkg::pose_t                 stk_top;
    logic [tpsg_pkg::STACK_CW-1:0]   stk_count;
    logic [tpsg_pkg::STACK_CW-1:0]   stk_count_next;

    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign cur_pose  = '{x: pos_x_reg, y: pos_y_reg, h: heading_reg};

    tpsg_seg_calc u_seg_calc
    (
        .step    (step_length_reg),
        .heading (heading_reg),
        .pos_x   (pos_x_reg),
        .pos_y   (pos_y_reg),
        .x_end   (seg_x_end),
        .y_end   (seg_y_end)
    );

    tpsg_pose_stack u_pose_stack
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (stk_ctrl),
        .pose_in    (cur_pose),
        .top        (stk_top),
        .count      (stk_count),
        .count_next (stk_count_next)
    );

    always_comb
    begin
        turn         = tpsg_pkg::wrap_deg({1'b0, turn_degrees_reg});
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        heading_next = heading_reg;
        status_next  = tpsg_pkg::STATUS_NONE;
        xs_next      = '0;
        ys_next      = '0;
        xe_next      = '0;
        ye_next      = '0;
        stk_ctrl     = '0;
        if (fire)
        begin
            if (in_restart_reg)
            begin
                pos_x_next     = $signed(start_x_reg);
                pos_y_next     = $signed(start_y_reg);
                heading_next   = tpsg_pkg::wrap_deg({1'b0, start_heading_reg});
                stk_ctrl.clear = 1'b1;
            end
            else
            begin
                case (in_sym_reg)
                    tpsg_pkg::SYM_FWD:
                    begin
                        status_next = tpsg_pkg::STATUS_SEGMENT;
                        xs_next     = pos_x_reg;
                        ys_next     = pos_y_reg;
                        xe_next     = seg_x_end;
                        ye_next     = seg_y_end;
                        pos_x_next  = seg_x_end;
                        pos_y_next  = seg_y_end;
                    end
                    tpsg_pkg::SYM_PLUS:
                    begin
                        heading_next = tpsg_pkg::wrap_deg({1'b0, heading_reg} + {1'b0, turn});
                    end
                    tpsg_pkg::SYM_MINUS:
                    begin
                        heading_next = tpsg_pkg::wrap_deg({1'b0, heading_reg} + 10'd360
                                                          - {1'b0, turn});
                    end
                    tpsg_pkg::SYM_PUSH:
                    begin
                        if (stk_count < tpsg_pkg::STACK_CW'(tpsg_pkg::STACK_DEPTH))
                            stk_ctrl.push = 1'b1;
                        else
                            status_next = tpsg_pkg::STATUS_OVERFLOW;
                    end
                    tpsg_pkg::SYM_POP:
                    begin
                        if (stk_count != '0)
                        begin
                            stk_ctrl.pop = 1'b1;
                            pos_x_next   = stk_top.x;
                            pos_y_next   = stk_top.y;
                            heading_next = stk_top.h;
                        end
                        else
                        begin
                            status_next = tpsg_pkg::STATUS_UNDERFLOW;
                        end
                    end
                    default:
                    begin
                        status_next = tpsg_pkg::STATUS_NONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_length_reg   <= tpsg_pkg::RST_STEP_LENGTH;
            turn_degrees_reg  <= tpsg_pkg::RST_TURN_DEGREES;
            start_x_reg       <= tpsg_pkg::RST_START_X;
            start_y_reg       <= tpsg_pkg::RST_START_Y;
            start_heading_reg <= tpsg_pkg::RST_START_HEADING;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tpsg_pkg::CFG_STEP_LENGTH:   step_length_reg   <= cfg_data[tpsg_pkg::STEP_W-1:0];
                tpsg_pkg::CFG_TURN_DEGREES:  turn_degrees_reg  <= cfg_data[tpsg_pkg::HEAD_W-1:0];
                tpsg_pkg::CFG_START_X:       start_x_reg       <= cfg_data;
                tpsg_pkg::CFG_START_Y:       start_y_reg       <= cfg_data;
                tpsg_pkg::CFG_START_HEADING: start_heading_reg <= cfg_data[tpsg_pkg::HEAD_W-1:0];
                default:
                begin
                    step_length_reg <= step_length_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= $signed(tpsg_pkg::RST_START_X);
            pos_y_reg     <= $signed(tpsg_pkg::RST_START_Y);
            heading_reg   <= tpsg_pkg::RST_START_HEADING;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
        end
    end

    // hold payload until the next beat is taken
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sym_reg     <= s_tdata;
            in_restart_reg <= s_tuser[0];
        end
        if (fire)
        begin
            status_reg <= status_next;
            xs_reg     <= xs_next;
            ys_reg     <= ys_next;
            xe_reg     <= xe_next;
            ye_reg     <= ye_next;
            level_reg  <= tpsg_pkg::LEVEL_W'(stk_count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, level_reg, ye_reg, xe_reg, ys_reg, xs_reg};

endmodule

`default_nettype wire

/* dv/turtle_path_segment_checker.sv */
`default_nettype none

module turtle_path_segment_checker
    import tpsg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [SYM_W-1:0]      s_tdata,
    input  wire logic [0:0]            s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic [STATUS_W-1:0]   m_tuser,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         errors,
    output int                         outstanding,
    output int                         results_checked,
    output int                         segments_seen,
    output int                         overflows_seen,
    output int                         underflows_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [STATUS_W-1:0] status;
        coord_t              x_start;
        coord_t              y_start;
        coord_t              x_end;
        coord_t              y_end;
        logic [LEVEL_W-1:0]  level;
    } segment_result_t;

    int unsigned sine_q15 [0:90] = '{
            0,   572,  1144,  1715,  2286,  2856,  3425,  3993,  4560,  5126,
         5690,  6252,  6813,  7371,  7927,  8481,  9032,  9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
        16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
        21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
        25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
        28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
        30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
        32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
        32767
    };

    int unsigned step_len;
    int unsigned turn_deg;
    coord_t      home_x;
    coord_t      home_y;
    int unsigned home_heading;

    int          pos_x;
    int          pos_y;
    int unsigned heading;
    int          saved_x [STACK_DEPTH];
    int          saved_y [STACK_DEPTH];
    int unsigned saved_h [STACK_DEPTH];
    int          depth;

    segment_result_t expected_q [$];
    segment_result_t want;
    coord_t          got_xs;
    coord_t          got_ys;
    coord_t          got_xe;
    coord_t          got_ye;

    task automatic report_mismatch(input string field, input int got, input int wanted);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, wanted);
        errors++;
    endtask

    function automatic coord_t clamp_q16_8(input int v);
        if (v > 8388607)
            return coord_t'(8388607);
        if (v < -8388608)
            return coord_t'(-8388608);
        return coord_t'(v);
    endfunction

    // step length times sin(deg), rounded half away from zero to Q16.8
    function automatic int step_component(input int unsigned deg);
        int unsigned       d;
        int unsigned       mag;
        longint unsigned   p;
        bit                neg;
        d   = deg % 360;
        neg = d > 180;
        if (d <= 90)
            mag = sine_q15[d];
        else if (d <= 180)
            mag = sine_q15[180 - d];
        else if (d <= 270)
            mag = sine_q15[d - 180];
        else
            mag = sine_q15[360 - d];
        p = (longint'(step_len) * mag + 16384) >> 15;
        return neg ? -int'(p) : int'(p);
    endfunction

    function automatic void reload_home();
        pos_x   = int'(home_x);
        pos_y   = int'(home_y);
        heading = home_heading % 360;
        depth   = 0;
    endfunction

    function automatic segment_result_t advance_turtle(input logic [SYM_W-1:0] sym,
                                                       input logic restart);
        segment_result_t r;
        int              dx;
        int              dy;
        int unsigned     turn;
        r.status  = STATUS_NONE;
        r.x_start = '0;
        r.y_start = '0;
        r.x_end   = '0;
        r.y_end   = '0;
        turn      = turn_deg % 360;
        if (restart)
            reload_home();
        else
        begin
            case (sym)
                SYM_FWD:
                begin
                    dx        = step_component(heading + 90);
                    dy        = step_component(heading);
                    r.x_start = coord_t'(pos_x);
                    r.y_start = coord_t'(pos_y);
                    r.x_end   = clamp_q16_8(pos_x + dx);
                    r.y_end   = clamp_q16_8(pos_y - dy);
                    pos_x     = int'(r.x_end);
                    pos_y     = int'(r.y_end);
                    r.status  = STATUS_SEGMENT;
                end
                SYM_PLUS:  heading = (heading + turn) % 360;
                SYM_MINUS: heading = (heading + 360 - turn) % 360;
                SYM_PUSH:
                begin
                    if (depth < STACK_DEPTH)
                    begin
                        saved_x[depth] = pos_x;
                        saved_y[depth] = pos_y;
                        saved_h[depth] = heading;
                        depth++;
                    end
                    else
                        r.status = STATUS_OVERFLOW;
                end
                SYM_POP:
                begin
                    if (depth > 0)
                    begin
                        depth--;
                        pos_x   = saved_x[depth];
                        pos_y   = saved_y[depth];
                        heading = saved_h[depth];
                    end
                    else
                        r.status = STATUS_UNDERFLOW;
                end
                default: ;
            endcase
        end
        r.level = LEVEL_W'(depth);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_len        = RST_STEP_LENGTH;
            turn_deg        = RST_TURN_DEGREES;
            home_x          = RST_START_X;
            home_y          = RST_START_Y;
            home_heading    = RST_START_HEADING;
            reload_home();
            expected_q.delete();
            errors          = 0;
            outstanding     = 0;
            results_checked = 0;
            segments_seen   = 0;
            overflows_seen  = 0;
            underflows_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (expected_q.size() == 0)
                    report_mismatch("beat with nothing expected, status", int'(m_tuser), -1);
                else
                begin
                    want   = expected_q.pop_front();
                    got_xs = m_tdata[23:0];
                    got_ys = m_tdata[47:24];
                    got_xe = m_tdata[71:48];
                    got_ye = m_tdata[95:72];
                    if (m_tuser != want.status)
                        report_mismatch("status", int'(m_tuser), int'(want.status));
                    if (got_xs != want.x_start)
                        report_mismatch("x_start", int'(got_xs), int'(want.x_start));
                    if (got_ys != want.y_start)
                        report_mismatch("y_start", int'(got_ys), int'(want.y_start));
                    if (got_xe != want.x_end)
                        report_mismatch("x_end", int'(got_xe), int'(want.x_end));
                    if (got_ye != want.y_end)
                        report_mismatch("y_end", int'(got_ye), int'(want.y_end));
                    if (m_tdata[102:96] != want.level)
                        report_mismatch("stack_level", int'(m_tdata[102:96]), int'(want.level));
                    if (m_tdata[103] != 1'b0)
                        report_mismatch("pad bit", int'(m_tdata[103]), 0);
                    case (want.status)
                        STATUS_SEGMENT:   segments_seen++;
                        STATUS_OVERFLOW:  overflows_seen++;
                        STATUS_UNDERFLOW: underflows_seen++;
                        default: ;
                    endcase
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STEP_LENGTH:   step_len     = cfg_data[STEP_W-1:0];
                    CFG_TURN_DEGREES:  turn_deg     = cfg_data[HEAD_W-1:0];
                    CFG_START_X:       home_x       = cfg_data;
                    CFG_START_Y:       home_y       = cfg_data;
                    CFG_START_HEADING: home_heading = cfg_data[HEAD_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(advance_turtle(s_tdata, s_tuser[0]));
            outstanding = expected_q.size();
        end
    end

endmodule

`default_nettype wire

/* dv/turtle_path_segment_generator_unit_tb.sv */
`default_nettype none

module turtle_path_segment_generator_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tpsg_pkg::*;

    localparam int                   IDLE_LIMIT   = 5000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SYM_W-1:0]      s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int outstanding;
    int results_checked;
    int segments_seen;
    int overflows_seen;
    int underflows_seen;

    int symbols_sent;
    int settings_used;
    int idle_cycles;
    int rx_wait;
    bit no_idle;

    turtle_path_segment_generator_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    turtle_path_segment_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .errors          (errors),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .segments_seen   (segments_seen),
        .overflows_seen  (overflows_seen),
        .underflows_seen (underflows_seen)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end
        else if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait  <= rx_wait - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_wait  <= idle_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic restart);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= restart;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        symbols_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
    endtask

    task automatic program_turtle(input logic [CFG_DATA_W-1:0] step, turn, sx, sy, sh,
                                  input bit poke_unmapped);
        wait_for_results();
        cfg_write(CFG_STEP_LENGTH, step);
        cfg_write(CFG_TURN_DEGREES, turn);
        cfg_write(CFG_START_X, sx);
        cfg_write(CFG_START_Y, sy);
        cfg_write(CFG_START_HEADING, sh);
        if (poke_unmapped)
            cfg_write(CFG_UNMAPPED, CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
        settings_used++;
        // reload the new start pose
        send_symbol(SYM_FWD, 1'b1);
    endtask

    task automatic send_random();
        int r;
        r = $urandom_range(0, 99);
        if (r < 34)
            send_symbol(SYM_FWD, 1'b0);
        else if (r < 46)
            send_symbol(SYM_PLUS, 1'b0);
        else if (r < 58)
            send_symbol(SYM_MINUS, 1'b0);
        else if (r < 72)
            send_symbol(SYM_PUSH, 1'b0);
        else if (r < 86)
            send_symbol(SYM_POP, 1'b0);
        else if (r < 89)
            send_symbol(SYM_W'($urandom_range(0, 255)), 1'b1);
        else
            send_symbol(SYM_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    endtask

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 20 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (i == n / 2)
                wait_for_results();
            send_random();
        end
        no_idle = 1'b0;
    endtask

    task automatic fill_branch_stack();
        for (int i = 0; i < STACK_DEPTH + 3; i++)
        begin
            send_symbol(SYM_PUSH, 1'b0);
            if ($urandom_range(0, 3) == 0)
                send_symbol($urandom_range(0, 1) ? SYM_FWD : SYM_PLUS, 1'b0);
        end
        for (int i = 0; i < STACK_DEPTH + 3; i++)
        begin
            send_symbol(SYM_POP, 1'b0);
            if ($urandom_range(0, 3) == 0)
                send_symbol($urandom_range(0, 1) ? SYM_FWD : SYM_MINUS, 1'b0);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        idle_cycles   <= 0;
        no_idle       = 1'b0;
        symbols_sent  = 0;
        settings_used = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_PLUS, 1'b0);
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(SYM_MINUS, 1'b0);
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_PUSH, 1'b0);
        send_symbol(SYM_FWD, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(SYM_PUSH, 1'b0);
        send_symbol(SYM_FWD, 1'b1);
        send_symbol(SYM_POP, 1'b0);
        send_symbol(8'h00, 1'b1);
        send_symbol(SYM_FWD, 1'b0);

        program_turtle(24'h00FFFF, 24'd359, 24'h7FFFFF, 24'h800000, 24'd0, 1'b0);
        fill_branch_stack();
        random_run(80);

        program_turtle(24'd0, 24'd0, 24'h800000, 24'h7FFFFF, 24'd359, 1'b0);
        random_run(100);

        program_turtle(CFG_DATA_W'($urandom()),
                       {15'($urandom()), 9'($urandom_range(360, 511))},
                       CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                       {15'($urandom()), 9'd511}, 1'b1);
        random_run(100);

        program_turtle(CFG_DATA_W'($urandom_range(256, 4096)), 24'd90, 24'd0, 24'd0,
                       CFG_DATA_W'($urandom_range(0, 359)), 1'b0);
        fill_branch_stack();
        random_run(80);

        wait_for_results();
        repeat (10) @(posedge clk);

        $display("Sent %0d symbols under %0d register settings, with restarts and a full stack.",
                 symbols_sent, settings_used);
        $display("Checked %0d results: %0d segments, %0d push overflows, %0d pop underflows.",
                 results_checked, segments_seen, overflows_seen, underflows_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
